FILE: sv/uuencode_block_checksum_core_macros.svh
// assertion macros for the uuencode block checksum core checker
// no dependencies; included by the checker file
`ifndef UUENCODE_BLOCK_CHECKSUM_CORE_MACROS_SVH
`define UUENCODE_BLOCK_CHECKSUM_CORE_MACROS_SVH

// same-cycle implication, quiet during reset
`define UUBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define UUBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define UUBC_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/uubc_pkg.sv
// shared types and constants of the uuencode block checksum core
// no dependencies; used by the front, queue, back and top files and the bench checker
`default_nettype none

package uubc_pkg;

  localparam int unsigned LINE_BYTES_DEF  = 45;
  localparam int unsigned BLOCK_LINES_DEF = 20;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned MAX_RESULTS     = 4;

  localparam logic [6:0] CHAR_OFFSET = 7'd32;
  localparam logic [6:0] ZERO_CHAR   = 7'd96;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_SUM  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [6:0]  character;
    logic        end_of_line;
    logic [17:0] block_sum;
  } result_t;

  // all results caused by one byte, slot 0 first
  typedef struct packed {
    logic [2:0]                   count;
    result_t [MAX_RESULTS-1:0]    res;
  } rec_t;

endpackage

`default_nettype wire

FILE: sv/uubc_if.sv
// valid/ready channel interfaces for input bytes and result beats
// no dependencies
`default_nettype none

interface uubc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface uubc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [6:0]  character;
  logic        end_of_line;
  logic [17:0] block_sum;
  logic        last;

  modport source (output valid, output kind, output character, output end_of_line,
                  output block_sum, output last, input ready);
  modport sink   (input valid, input kind, input character, input end_of_line,
                  input block_sum, input last, output ready);
endinterface

`default_nettype wire

FILE: sv/uubc_front.sv
// front end: takes bytes, keeps line/block state, builds the result list of each byte
// depends on uubc_pkg and uubc_in_if
`default_nettype none

module uubc_front #(
  parameter int unsigned LINE_BYTES  = uubc_pkg::LINE_BYTES_DEF,
  parameter int unsigned BLOCK_LINES = uubc_pkg::BLOCK_LINES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  uubc_in_if.sink          in_ch,
  input  wire logic        q_full,
  output logic             push,
  output uubc_pkg::rec_t   rec
);

  localparam int unsigned LW = $clog2(LINE_BYTES + 1);
  localparam int unsigned BW = $clog2(BLOCK_LINES + 1);

  logic [31:0]   bytes_remaining;
  logic [LW-1:0] bytes_in_line;
  logic [BW-1:0] lines_in_block;
  logic [3:0]    leftover_bits;
  logic [1:0]    leftover_pairs;
  logic [17:0]   sum_accumulator;

  logic          accept;
  logic          header;
  logic          line_end;
  logic          block_end;
  logic          two_data;
  logic          flush_v;
  logic [LW-1:0] hdr_len;
  logic [LW-1:0] bytes_in_line_next;
  logic [BW-1:0] lines_in_block_next;
  logic [17:0]   sum_next;
  logic [5:0]    d0;
  logic [5:0]    d1;
  logic [5:0]    flush_grp;
  logic [3:0]    leftover_bits_next;
  logic [1:0]    leftover_pairs_next;
  logic [2:0]    n;

  function automatic logic [6:0] enc6(input logic [5:0] v);
    return (v == 6'd0) ? uubc_pkg::ZERO_CHAR : ({1'b0, v} + uubc_pkg::CHAR_OFFSET);
  endfunction

  function automatic uubc_pkg::result_t mk_char(input logic [6:0] c, input logic eol);
    uubc_pkg::result_t r;
    r.kind        = uubc_pkg::KIND_TEXT;
    r.character   = c;
    r.end_of_line = eol;
    r.block_sum   = '0;
    return r;
  endfunction

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign push        = accept && (bytes_remaining != 32'd0);

  assign header              = (bytes_in_line == '0);
  assign hdr_len             = (bytes_remaining < 32'(LINE_BYTES)) ?
                               bytes_remaining[LW-1:0] : LW'(LINE_BYTES);
  assign bytes_in_line_next  = bytes_in_line + LW'(1);
  assign lines_in_block_next = lines_in_block + BW'(1);
  assign line_end            = (bytes_in_line_next == LW'(LINE_BYTES)) ||
                               (bytes_remaining == 32'd1);
  assign block_end           = line_end && ((lines_in_block_next == BW'(BLOCK_LINES)) ||
                                            (bytes_remaining == 32'd1));
  assign sum_next            = sum_accumulator + {10'd0, in_ch.data_byte};

  // split the byte into 6-bit groups by how many leftover bits are pending
  always_comb begin
    d1 = in_ch.data_byte[5:0];
    case (leftover_pairs)
      2'd0: begin
        d0                  = in_ch.data_byte[7:2];
        two_data            = 1'b0;
        leftover_bits_next  = {2'b00, in_ch.data_byte[1:0]};
        leftover_pairs_next = 2'd1;
        flush_grp           = {in_ch.data_byte[1:0], 4'b0000};
      end
      2'd1: begin
        d0                  = {leftover_bits[1:0], in_ch.data_byte[7:4]};
        two_data            = 1'b0;
        leftover_bits_next  = in_ch.data_byte[3:0];
        leftover_pairs_next = 2'd2;
        flush_grp           = {in_ch.data_byte[3:0], 2'b00};
      end
      default: begin
        d0                  = {leftover_bits, in_ch.data_byte[7:6]};
        two_data            = 1'b1;
        leftover_bits_next  = 4'd0;
        leftover_pairs_next = 2'd0;
        flush_grp           = 6'd0;
      end
    endcase
    flush_v = line_end && !two_data;
  end

  // result list in output order
  always_comb begin
    rec = '0;
    n   = 3'd0;
    if (header) begin
      rec.res[n[1:0]] = mk_char(7'(hdr_len) + uubc_pkg::CHAR_OFFSET, 1'b0);
      n = n + 3'd1;
    end
    rec.res[n[1:0]] = mk_char(enc6(d0), line_end && !flush_v && !two_data);
    n = n + 3'd1;
    if (two_data) begin
      rec.res[n[1:0]] = mk_char(enc6(d1), line_end);
      n = n + 3'd1;
    end
    if (flush_v) begin
      rec.res[n[1:0]] = mk_char(enc6(flush_grp), 1'b1);
      n = n + 3'd1;
    end
    if (block_end) begin
      rec.res[n[1:0]].kind      = uubc_pkg::KIND_SUM;
      rec.res[n[1:0]].block_sum = sum_next;
      n = n + 3'd1;
    end
    rec.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      bytes_in_line   <= '0;
      lines_in_block  <= '0;
      leftover_bits   <= '0;
      leftover_pairs  <= '0;
      sum_accumulator <= '0;
    end else if (cfg_we) begin
      bytes_remaining <= cfg_wdata;
      bytes_in_line   <= '0;
      lines_in_block  <= '0;
      leftover_bits   <= '0;
      leftover_pairs  <= '0;
      sum_accumulator <= '0;
    end else if (push) begin
      bytes_remaining <= bytes_remaining - 32'd1;
      sum_accumulator <= block_end ? 18'd0 : sum_next;
      if (line_end) begin
        bytes_in_line  <= '0;
        leftover_bits  <= '0;
        leftover_pairs <= '0;
        lines_in_block <= block_end ? '0 : lines_in_block_next;
      end else begin
        bytes_in_line  <= bytes_in_line_next;
        leftover_bits  <= leftover_bits_next;
        leftover_pairs <= leftover_pairs_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/uubc_queue.sv
// short fifo of per-byte result lists between front and back end
// depends on uubc_pkg
`default_nettype none

module uubc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire uubc_pkg::rec_t  wr_rec,
  input  wire logic            pop,
  output logic                 full,
  output logic                 not_empty,
  output uubc_pkg::rec_t       head
);

  localparam int unsigned DEPTH = uubc_pkg::QUEUE_DEPTH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  uubc_pkg::rec_t entries [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    fill;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full      = (fill == (AW + 1)'(DEPTH));
  assign not_empty = (fill != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      fill <= fill + (AW + 1)'(1);
      else if (pop && !push) fill <= fill - (AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_rec;
  end

endmodule

`default_nettype wire

FILE: sv/uubc_back.sv
// back end: walks the head result list one beat at a time into the output register
// depends on uubc_pkg and uubc_out_if
`default_nettype none

module uubc_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire uubc_pkg::rec_t  head,
  output logic                 pop,
  uubc_out_if.source           out_ch
);

  logic       out_valid;
  logic [1:0] idx;
  logic       load;
  logic       is_last;
  uubc_pkg::result_t sel;

  assign load    = q_valid && (!out_valid || out_ch.ready);
  assign is_last = (({1'b0, idx} + 3'd1) == head.count);
  assign pop     = load && is_last;
  assign sel     = head.res[idx];

  assign out_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= is_last ? 2'd0 : idx + 2'd1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.kind        <= sel.kind;
      out_ch.character   <= sel.character;
      out_ch.end_of_line <= sel.end_of_line;
      out_ch.block_sum   <= sel.block_sum;
      out_ch.last        <= is_last;
    end
  end

endmodule

`default_nettype wire

FILE: sv/uuencode_block_checksum_core.sv
// uuencode-style line encoder with per-block byte sums
// Channels: in_ch carries one raw byte per beat (valid/ready); out_ch carries one
// result per beat: a text character (kind 0) or a block checksum (kind 1), with
// end_of_line on the last character of a line and last on the final result of
// the byte. cfg_we/cfg_wdata load the transfer length and restart the stream;
// write only while the block is idle.
// Each byte gives one to four results: an optional length character, one or two
// group characters, an optional flush character and an optional checksum.
// A byte accepted on in_ch is written into the queue and then loaded from the
// queue head into the output register, from which its first result beat is taken.
// Results leave at one per cycle while the receiver is ready, set by the single
// output register; a byte holds the queue head until its last result is loaded.
// A byte past the end of the transfer is taken and gives nothing.
// A two-entry queue sits between the byte front end and the output side, so
// bytes keep flowing while the receiver stalls until the queue fills.
// Reset clears the stream state and the length, so bytes are dropped until a
// length is written; nothing is shown on out_ch after reset.
// depends on uubc_pkg, uubc_if, uubc_front, uubc_queue, uubc_back
`default_nettype none

module uuencode_block_checksum_core #(
  parameter int unsigned LINE_BYTES  = uubc_pkg::LINE_BYTES_DEF,
  parameter int unsigned BLOCK_LINES = uubc_pkg::BLOCK_LINES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  uubc_in_if.sink          in_ch,
  uubc_out_if.source       out_ch
);

  // front to queue
  logic           push;
  uubc_pkg::rec_t wr_rec;
  logic           q_full;
  // queue to back
  logic           q_valid;
  logic           pop;
  uubc_pkg::rec_t head;

  // byte intake, line/block counters and result list building
  uubc_front #(
    .LINE_BYTES  (LINE_BYTES),
    .BLOCK_LINES (BLOCK_LINES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .rec       (wr_rec)
  );

  // decoupling queue, one entry per producing byte
  uubc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_rec    (wr_rec),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head)
  );

  // serializer into the registered output beat
  uubc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

FILE: sv/uubc_checker.sv
// port-level checks of the uuencode block checksum core, bound to the top level
// depends on uuencode_block_checksum_core_macros.svh
`default_nettype none
`include "uuencode_block_checksum_core_macros.svh"

module uubc_port_checks (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_kind,
  input wire logic [6:0]  out_character,
  input wire logic        out_eol,
  input wire logic        out_last,
  input wire logic [17:0] out_block_sum
);

  // a checksum always closes the results of its byte
  `UUBC_ASSERT_NOW(a_sum_is_last, out_valid && out_kind == 1'b1, out_last, "checksum beat without last")

  // end of line only on text beats
  `UUBC_ASSERT_NOW(a_eol_text, out_valid && out_eol, out_kind == 1'b0, "end_of_line on checksum beat")

  // stalled beat holds
  `UUBC_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_character) && $stable(out_eol) && $stable(out_last) && $stable(out_block_sum), "stalled beat changed")

  // reset empties the output register
  `UUBC_ASSERT_ALWAYS(a_reset_quiet, rst, !out_valid, "output valid right after reset")

endmodule

bind uuencode_block_checksum_core uubc_port_checks u_uubc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_kind      (out_ch.kind),
  .out_character (out_ch.character),
  .out_eol       (out_ch.end_of_line),
  .out_last      (out_ch.last),
  .out_block_sum (out_ch.block_sum)
);

`default_nettype wire

FILE: tb/uubc_checker.sv
// line encoder checker: watches the byte and result channels and the length writes,
// predicts every result beat and compares it field by field in arrival order
// depends on uubc_pkg and uubc_if
module uubc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  uubc_in_if          in_ch,
  uubc_out_if         out_ch,
  output int          failures,
  output int          beats_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        kind;
    logic [6:0]  character;
    logic        end_of_line;
    logic [17:0] block_sum;
    logic        last;
  } enc_beat_t;

  // encoder state as the block should hold it
  logic [31:0] bytes_left;
  int unsigned line_fill;
  int unsigned block_lines;
  logic [3:0]  carry_bits;
  int unsigned carry_width;
  logic [17:0] block_total;

  enc_beat_t encoded_due[$];
  int        fail_count = 0;
  int        due_count  = 0;

  assign failures  = fail_count;
  assign beats_due = due_count;

  function automatic logic [6:0] group_char(input logic [5:0] grp);
    return (grp == 6'd0) ? uubc_pkg::ZERO_CHAR : {1'b0, grp} + uubc_pkg::CHAR_OFFSET;
  endfunction

  function automatic enc_beat_t text_beat(input logic [6:0] ch);
    enc_beat_t b;
    b = '0;
    b.kind = uubc_pkg::KIND_TEXT;
    b.character = ch;
    return b;
  endfunction

  task automatic restart_stream(input logic [31:0] length);
    bytes_left  = length;
    line_fill   = 0;
    block_lines = 0;
    carry_bits  = '0;
    carry_width = 0;
    block_total = '0;
  endtask

  task automatic encode_byte(input logic [7:0] data);
    enc_beat_t   sum_beat;
    logic [11:0] merged;
    int unsigned nbits;
    int unsigned len;
    bit          line_done;
    if (bytes_left == 0) return;
    // a new line opens with its length character
    if (line_fill == 0) begin
      len = (bytes_left < uubc_pkg::LINE_BYTES_DEF) ? bytes_left : uubc_pkg::LINE_BYTES_DEF;
      encoded_due.push_back(text_beat(7'(len) + uubc_pkg::CHAR_OFFSET));
    end
    bytes_left  = bytes_left - 1;
    line_fill   = line_fill + 1;
    block_total = block_total + 18'(data);
    line_done   = (line_fill >= uubc_pkg::LINE_BYTES_DEF) || (bytes_left == 0);
    merged = {carry_bits, data};
    nbits  = carry_width + 8;
    while (nbits >= 6) begin
      encoded_due.push_back(text_beat(group_char(6'(merged >> (nbits - 6)))));
      nbits = nbits - 6;
    end
    carry_bits  = merged[3:0] & 4'((1 << nbits) - 1);
    carry_width = nbits;
    if (line_done) begin
      // partial group shifted up, no padding
      if (carry_width > 0)
        encoded_due.push_back(text_beat(group_char(6'({2'b00, carry_bits} << (6 - carry_width)))));
      encoded_due[encoded_due.size() - 1].end_of_line = 1'b1;
      carry_bits  = '0;
      carry_width = 0;
      line_fill   = 0;
      block_lines = block_lines + 1;
      if (block_lines >= uubc_pkg::BLOCK_LINES_DEF || bytes_left == 0) begin
        sum_beat = '0;
        sum_beat.kind = uubc_pkg::KIND_SUM;
        sum_beat.block_sum = block_total;
        encoded_due.push_back(sum_beat);
        block_total = '0;
        block_lines = 0;
      end
    end
    encoded_due[encoded_due.size() - 1].last = 1'b1;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    enc_beat_t want;
    if (rst) begin
      restart_stream('0);
      encoded_due.delete();
    end else begin
      if (cfg_we)
        restart_stream(cfg_wdata);
      if (in_ch.valid && in_ch.ready)
        encode_byte(in_ch.data_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (encoded_due.size() == 0) begin
          $error("unexpected result beat: kind %0d character %0d block_sum %0d",
                 out_ch.kind, out_ch.character, out_ch.block_sum);
          fail_count++;
        end else begin
          want = encoded_due.pop_front();
          check_field("kind", want.kind, out_ch.kind);
          check_field("character", want.character, out_ch.character);
          check_field("end_of_line", want.end_of_line, out_ch.end_of_line);
          check_field("block_sum", want.block_sum, out_ch.block_sum);
          check_field("last", want.last, out_ch.last);
        end
      end
    end
    due_count = encoded_due.size();
  end

endmodule

FILE: tb/testbench.sv
// top of the uuencode block checksum core bench: clock, reset, length writes,
// byte stimulus and receiver stalls; the checker beside the block judges the results
// depends on uubc_pkg, uubc_if, uubc_checker and uuencode_block_checksum_core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int SETTLE_TICKS = 8;       // quiet cycles after the results drain
  localparam int HOLD_TICKS   = 80;      // long receiver hold-off
  localparam int RANDOM_BYTES = 140;
  localparam int LONG_XFER    = 100;     // two full lines plus a short one
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  uubc_in_if  byte_ch ();
  uubc_out_if result_ch ();

  int failures;
  int beats_due;
  int cycle_count = 0;

  bit idle_on  = 1'b1;   // random bursts of idling on both sides
  bit hold_req = 1'b0;   // ask the receiver for one long hold-off

  uuencode_block_checksum_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (byte_ch),
    .out_ch    (result_ch)
  );

  uubc_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (byte_ch),
    .out_ch    (result_ch),
    .failures  (failures),
    .beats_due (beats_due)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // receiver: one drive per falling edge at most, with random bursts of stalls
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long hold-off so the internal queue fills and the byte side backs up
        result_ch.ready <= 1'b0;
        repeat (HOLD_TICKS - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // offer one byte, called at a falling edge, returns at the falling edge after the beat
  task automatic send_byte(input logic [7:0] data);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= data;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // let every predicted beat arrive, then a few quiet cycles for dropped bytes
  task automatic drain_results();
    byte_ch.valid <= 1'b0;
    @(negedge clk);
    while (beats_due != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  // length write restarts the transfer; only issued while the block is idle
  task automatic load_length(input logic [31:0] length);
    cfg_we    <= 1'b1;
    cfg_wdata <= length;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // random byte with extra weight on the all-zero and all-one patterns
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : stimulus
    int sent;
    int length;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    rst               = 1'b1;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty transfer: bytes are dropped without any result
    load_length(32'd0);
    send_byte(8'h5A);
    send_byte(8'hA5);
    drain_results();

    // single zero byte: backtick groups and a two-bit flush
    load_length(32'd1);
    send_byte(8'h00);
    drain_results();

    // two bytes, four-bit flush on the last group
    load_length(32'd2);
    send_byte(8'hFF);
    send_byte(8'h80);
    drain_results();

    // three bytes end on a group boundary, then a byte past the end is dropped
    load_length(32'd3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h3C);
    send_byte(8'h77);
    drain_results();

    // largest length: lines never run out, the next write restarts mid-line
    load_length(32'hFFFF_FFFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(8'h01);
    drain_results();

    // random transfers, mostly short, some spanning several lines;
    // the first one is long so the hold-off backs up the byte side
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      length = (sent == 0 || $urandom_range(0, 4) == 0) ? $urandom_range(46, 140) :
                                                          $urandom_range(1, 60);
      load_length(length);
      if (sent == 0)
        hold_req = 1'b1;
      for (int i = 0; i < length; i++)
        send_byte(pick_byte());
      // occasional bytes past the end of the transfer
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) send_byte(pick_byte());
      sent += length;
      drain_results();
    end

    // closing stretch without idling: full lines back to back,
    // then a short tail line and a block closed by the end of the data
    idle_on = 1'b0;
    load_length(LONG_XFER);
    for (int i = 0; i < LONG_XFER; i++)
      send_byte(pick_byte());
    drain_results();

    if (failures == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

FILE: uuencode_block_checksum_core.f
+incdir+sv
sv/uubc_pkg.sv
sv/uubc_if.sv
sv/uubc_front.sv
sv/uubc_queue.sv
sv/uubc_back.sv
sv/uuencode_block_checksum_core.sv
sv/uubc_checker.sv
tb/uubc_checker.sv
tb/testbench.sv
